// ===== rtl/frla_pkg.sv =====
// ----------------------------------------------------------------------------
// frla_pkg
// Shared constants, types and helpers for the first-fit range allocator.
// ----------------------------------------------------------------------------
package frla_pkg;

    localparam int MAX_RANGES = 64;
    localparam int SLOT_BITS  = 20;
    localparam int IDX_W      = $clog2(MAX_RANGES);
    localparam int CNT_W      = $clog2(MAX_RANGES + 1);
    localparam int FIRST_W    = SLOT_BITS + 1;
    localparam int ENTRY_W    = FIRST_W + SLOT_BITS;

    localparam logic [1:0] CMD_ALLOC   = 2'd0;
    localparam logic [1:0] CMD_FREE    = 2'd1;
    localparam logic [1:0] CMD_RESTORE = 2'd2;

    localparam logic [1:0] STATUS_DONE    = 2'd0;
    localparam logic [1:0] STATUS_REFUSED = 2'd1;
    localparam logic [1:0] STATUS_FULL    = 2'd2;

    localparam logic [2:0] WR_NONE    = 3'd0;
    localparam logic [2:0] WR_RESTORE = 3'd1;
    localparam logic [2:0] WR_TRIM    = 3'd2;
    localparam logic [2:0] WR_PULL    = 3'd3;
    localparam logic [2:0] WR_MERGE   = 3'd4;
    localparam logic [2:0] WR_PUSH    = 3'd5;
    localparam logic [2:0] WR_INSERT  = 3'd6;

    localparam logic [2:0] IDX_HOLD   = 3'd0;
    localparam logic [2:0] IDX_ZERO   = 3'd1;
    localparam logic [2:0] IDX_INC    = 3'd2;
    localparam logic [2:0] IDX_DEC    = 3'd3;
    localparam logic [2:0] IDX_TOP    = 3'd4;

    localparam logic [2:0] REG_TOTAL_COUNT = 3'd0;

    typedef struct packed {
        logic       load;
        logic [2:0] idx_op;
        logic [2:0] wr_op;
        logic       cnt_inc;
        logic       cnt_dec;
        logic       status_we;
        logic [1:0] status_val;
        logic       grant_we;
        logic       prev_we;
        logic       ins_we;
        logic       out_load;
    } frla_ctrl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       count_zero;
        logic       idx_lt_cnt;
        logic       fits;
        logic       exact;
        logic       more;
        logic       ahead;
        logic       merge_ok;
        logic       full;
        logic       idx_eq_cnt;
        logic       idx_gt_ins;
        logic       out_free;
    } frla_stat_t;

    function automatic logic [FIRST_W-1:0] pool_size(input logic [FIRST_W-1:0] tc);
        logic [FIRST_W-1:0] p;
        p = tc;
        if (tc == '0) begin
            p = FIRST_W'(1);
        end else if (tc > (FIRST_W'(1) << SLOT_BITS)) begin
            p = FIRST_W'(1) << SLOT_BITS;
        end
        return p;
    endfunction

    function automatic logic [FIRST_W-1:0] range_size(input logic [FIRST_W-1:0] first,
                                                      input logic [SLOT_BITS-1:0] last);
        logic [FIRST_W-1:0] s;
        if (first > {1'b0, last}) begin
            s = '0;
        end else begin
            s = {1'b0, last} + FIRST_W'(1) - first;
        end
        return s;
    endfunction

endpackage

// ===== rtl/frla_ram.sv =====
// ----------------------------------------------------------------------------
// frla_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module frla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/frla_ctrl.sv =====
// ----------------------------------------------------------------------------
// frla_ctrl
// Command sequencer: scans, shifts and updates the range table.
// ----------------------------------------------------------------------------
module frla_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  frla_pkg::frla_stat_t stat,
    output frla_pkg::frla_ctrl_t ctrl
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_DECODE  = 3'd1;
    localparam logic [2:0] ST_A_SCAN  = 3'd2;
    localparam logic [2:0] ST_A_PULL  = 3'd3;
    localparam logic [2:0] ST_F_SCAN  = 3'd4;
    localparam logic [2:0] ST_F_PUSH  = 3'd5;
    localparam logic [2:0] ST_F_INS   = 3'd6;
    localparam logic [2:0] ST_FINISH  = 3'd7;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        ctrl       = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctrl.load  = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                if ((stat.cmd == frla_pkg::CMD_ALLOC || stat.cmd == frla_pkg::CMD_FREE)
                    && stat.count_zero) begin
                    ctrl.status_we  = 1'b1;
                    ctrl.status_val = frla_pkg::STATUS_REFUSED;
                    state_next      = ST_FINISH;
                end else if (stat.cmd == frla_pkg::CMD_ALLOC) begin
                    ctrl.idx_op = frla_pkg::IDX_ZERO;
                    state_next  = ST_A_SCAN;
                end else if (stat.cmd == frla_pkg::CMD_FREE) begin
                    ctrl.idx_op = frla_pkg::IDX_ZERO;
                    state_next  = ST_F_SCAN;
                end else if (stat.cmd == frla_pkg::CMD_RESTORE) begin
                    ctrl.wr_op = frla_pkg::WR_RESTORE;
                    state_next = ST_FINISH;
                end else begin
                    state_next = ST_FINISH;
                end
            end
            ST_A_SCAN: begin
                if (!stat.idx_lt_cnt) begin
                    ctrl.status_we  = 1'b1;
                    ctrl.status_val = frla_pkg::STATUS_REFUSED;
                    state_next      = ST_FINISH;
                end else if (stat.fits) begin
                    ctrl.grant_we = 1'b1;
                    if (stat.exact && stat.more) begin
                        ctrl.idx_op = frla_pkg::IDX_INC;
                        state_next  = ST_A_PULL;
                    end else begin
                        ctrl.wr_op = frla_pkg::WR_TRIM;
                        state_next = ST_FINISH;
                    end
                end else begin
                    ctrl.idx_op = frla_pkg::IDX_INC;
                end
            end
            ST_A_PULL: begin
                ctrl.wr_op = frla_pkg::WR_PULL;
                if (stat.more) begin
                    ctrl.idx_op = frla_pkg::IDX_INC;
                end else begin
                    ctrl.cnt_dec = 1'b1;
                    state_next   = ST_FINISH;
                end
            end
            ST_F_SCAN: begin
                if (stat.idx_lt_cnt && stat.ahead) begin
                    ctrl.prev_we = 1'b1;
                    ctrl.idx_op  = frla_pkg::IDX_INC;
                end else if (stat.merge_ok) begin
                    ctrl.wr_op = frla_pkg::WR_MERGE;
                    state_next = ST_FINISH;
                end else if (stat.full) begin
                    ctrl.status_we  = 1'b1;
                    ctrl.status_val = frla_pkg::STATUS_FULL;
                    state_next      = ST_FINISH;
                end else begin
                    ctrl.ins_we = 1'b1;
                    if (stat.idx_eq_cnt) begin
                        state_next = ST_F_INS;
                    end else begin
                        ctrl.idx_op = frla_pkg::IDX_TOP;
                        state_next  = ST_F_PUSH;
                    end
                end
            end
            ST_F_PUSH: begin
                ctrl.wr_op = frla_pkg::WR_PUSH;
                if (stat.idx_gt_ins) begin
                    ctrl.idx_op = frla_pkg::IDX_DEC;
                end else begin
                    state_next = ST_F_INS;
                end
            end
            ST_F_INS: begin
                ctrl.wr_op   = frla_pkg::WR_INSERT;
                ctrl.cnt_inc = 1'b1;
                state_next   = ST_FINISH;
            end
            ST_FINISH: begin
                if (stat.out_free) begin
                    ctrl.out_load = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/frla_datapath.sv =====
// ----------------------------------------------------------------------------
// frla_datapath
// Range table, command registers, comparators and result register.
// ----------------------------------------------------------------------------
module frla_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  frla_pkg::frla_ctrl_t ctrl,
    output frla_pkg::frla_stat_t stat,
    input  logic [1:0]           in_cmd,
    input  logic [20:0]          in_count,
    input  logic [19:0]          in_offset,
    input  logic                 cfg_we,
    input  logic [20:0]          cfg_data,
    output logic [20:0]          total_count,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [1:0]           m_status,
    output logic [19:0]          m_alloc_offset,
    output logic                 m_pool_empty
);

    localparam int FW = frla_pkg::FIRST_W;
    localparam int SW = frla_pkg::SLOT_BITS;
    localparam int CW = frla_pkg::CNT_W;
    localparam int IW = frla_pkg::IDX_W;
    localparam logic [SW-1:0] MAX_SLOT = {SW{1'b1}};

    logic [20:0]    total_reg;
    logic [1:0]     cmd_reg;
    logic [20:0]    count_reg;
    logic [SW-1:0]  off_reg;
    logic [SW-1:0]  blk_last_reg;
    logic [CW-1:0]  idx_reg, idx_next;
    logic [CW-1:0]  cnt_reg, cnt_next;
    logic [CW-1:0]  ins_reg;
    logic [FW-1:0]  prev_first_reg;
    logic [SW-1:0]  prev_last_reg;
    logic [FW-1:0]  e0_first_reg;
    logic [SW-1:0]  e0_last_reg;
    logic [1:0]     status_reg;
    logic [SW-1:0]  grant_reg;
    logic           out_valid_reg;
    logic [1:0]     out_status_reg;
    logic [SW-1:0]  out_grant_reg;
    logic           out_empty_reg;

    logic [frla_pkg::ENTRY_W-1:0] rdata, wdata;
    logic [IW-1:0]  waddr;
    logic           we;
    logic [FW-1:0]  r_first;
    logic [SW-1:0]  r_last;
    logic [FW-1:0]  r_size;
    logic [SW+1:0]  blk_sum;
    logic [SW-1:0]  blk_last;
    logic [SW+1:0]  merge_sum;
    logic [SW-1:0]  merged;
    logic [FW-1:0]  blk_end;
    logic [FW-1:0]  cfg_pool;
    logic [FW-1:0]  cur_pool;

    assign r_first  = rdata[frla_pkg::ENTRY_W-1:SW];
    assign r_last   = rdata[SW-1:0];
    assign r_size   = frla_pkg::range_size(r_first, r_last);
    assign cfg_pool = frla_pkg::pool_size(cfg_data);
    assign cur_pool = frla_pkg::pool_size(total_reg);
    assign blk_sum  = {2'b00, in_offset} + {1'b0, in_count} - (SW+2)'(1);
    assign blk_last = (blk_sum > {2'b00, MAX_SLOT}) ? MAX_SLOT : blk_sum[SW-1:0];
    assign blk_end  = {1'b0, blk_last_reg} + FW'(1);
    assign merge_sum = {2'b00, prev_last_reg} + {1'b0, count_reg};
    assign merged   = (merge_sum > {2'b00, MAX_SLOT}) ? MAX_SLOT : merge_sum[SW-1:0];

    always_comb begin
        case (ctrl.idx_op)
            frla_pkg::IDX_ZERO: idx_next = '0;
            frla_pkg::IDX_INC:  idx_next = idx_reg + CW'(1);
            frla_pkg::IDX_DEC:  idx_next = idx_reg - CW'(1);
            frla_pkg::IDX_TOP:  idx_next = cnt_reg - CW'(1);
            default:            idx_next = idx_reg;
        endcase
    end

    always_comb begin
        we    = 1'b1;
        waddr = '0;
        wdata = {{FW{1'b0}}, cfg_pool[SW-1:0] - SW'(1)};
        if (!aresetn) begin
            // entry 0 covers the whole default pool
            wdata = {{FW{1'b0}}, MAX_SLOT};
        end else if (cfg_we) begin
            wdata = {{FW{1'b0}}, cfg_pool[SW-1:0] - SW'(1)};
        end else begin
            case (ctrl.wr_op)
                frla_pkg::WR_RESTORE: begin
                    wdata = {{FW{1'b0}}, cur_pool[SW-1:0] - SW'(1)};
                end
                frla_pkg::WR_TRIM: begin
                    waddr = idx_reg[IW-1:0];
                    wdata = {r_first + count_reg, r_last};
                end
                frla_pkg::WR_PULL: begin
                    waddr = IW'(idx_reg - CW'(1));
                    wdata = rdata;
                end
                frla_pkg::WR_MERGE: begin
                    waddr = IW'(idx_reg - CW'(1));
                    wdata = {prev_first_reg, merged};
                end
                frla_pkg::WR_PUSH: begin
                    waddr = IW'(idx_reg + CW'(1));
                    wdata = rdata;
                end
                frla_pkg::WR_INSERT: begin
                    waddr = ins_reg[IW-1:0];
                    wdata = {1'b0, off_reg, blk_last_reg};
                end
                default: begin
                    we = 1'b0;
                end
            endcase
        end
    end

    frla_ram #(
        .WIDTH (frla_pkg::ENTRY_W),
        .DEPTH (frla_pkg::MAX_RANGES)
    ) u_table (
        .aclk  (aclk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (idx_next[IW-1:0]),
        .rdata (rdata)
    );

    always_comb begin
        cnt_next = cnt_reg;
        if (cfg_we || ctrl.wr_op == frla_pkg::WR_RESTORE) begin
            cnt_next = CW'(1);
        end else if (ctrl.cnt_inc) begin
            cnt_next = cnt_reg + CW'(1);
        end else if (ctrl.cnt_dec) begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            total_reg     <= 21'h100000;
            cnt_reg       <= CW'(1);
            e0_first_reg  <= '0;
            e0_last_reg   <= MAX_SLOT;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                total_reg <= cfg_data;
            end
            cnt_reg <= cnt_next;
            if (we && waddr == '0) begin
                e0_first_reg <= wdata[frla_pkg::ENTRY_W-1:SW];
                e0_last_reg  <= wdata[SW-1:0];
            end
            if (ctrl.out_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg <= idx_next;
        if (ctrl.load) begin
            cmd_reg      <= in_cmd;
            count_reg    <= in_count;
            off_reg      <= in_offset;
            blk_last_reg <= blk_last;
            status_reg   <= frla_pkg::STATUS_DONE;
            grant_reg    <= '0;
        end
        if (ctrl.status_we) begin
            status_reg <= ctrl.status_val;
        end
        if (ctrl.grant_we) begin
            grant_reg <= r_first[SW-1:0];
        end
        if (ctrl.prev_we) begin
            prev_first_reg <= r_first;
            prev_last_reg  <= r_last;
        end
        if (ctrl.ins_we) begin
            ins_reg <= idx_reg;
        end
        if (ctrl.out_load) begin
            out_status_reg <= status_reg;
            out_grant_reg  <= grant_reg;
            out_empty_reg  <= (cnt_reg == CW'(1))
                              && (frla_pkg::range_size(e0_first_reg, e0_last_reg) == cur_pool);
        end
    end

    assign stat.cmd        = cmd_reg;
    assign stat.count_zero = (count_reg == '0);
    assign stat.idx_lt_cnt = (idx_reg < cnt_reg);
    assign stat.fits       = (count_reg <= r_size);
    assign stat.exact      = (count_reg == r_size);
    assign stat.more       = ((idx_reg + CW'(1)) < cnt_reg);
    assign stat.ahead      = (r_first < blk_end);
    assign stat.merge_ok   = (idx_reg != '0)
                             && (({1'b0, prev_last_reg} + FW'(1)) == {1'b0, off_reg});
    assign stat.full       = (cnt_reg >= CW'(frla_pkg::MAX_RANGES));
    assign stat.idx_eq_cnt = (idx_reg == cnt_reg);
    assign stat.idx_gt_ins = (idx_reg > ins_reg);
    assign stat.out_free   = !out_valid_reg || m_tready;

    assign total_count    = total_reg;
    assign m_tvalid       = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_alloc_offset = out_grant_reg;
    assign m_pool_empty   = out_empty_reg;

endmodule

// ===== rtl/range_free_list_allocator.sv =====
// ----------------------------------------------------------------------------
// range_free_list_allocator
// First-fit allocator over a pool of slots, kept as an ordered table of free
// ranges.
//
// The input stream carries one command per transaction: allocate, free or
// restore the table to one range over the whole pool. Each command yields
// exactly one result transaction with a status, the granted offset and the
// empty flag. The APB port holds the pool size; writing it also restores
// the table.
// One command is worked on at a time. An allocate scans the table from
// entry 0 for the first range that fits; when it uses up a range that is
// not the last, the entries behind it are moved down one at a time. A free
// scans to its place and either merges with the range before it or moves
// the entries behind it up one at a time and inserts a new range, or reports
// the table full. The single table read and write port steps one entry a
// cycle. Restore and refused commands go straight to the result. The next
// command can be taken in the same cycle as the result appears.
// After reset the pool holds 1048576 slots and the table one full range;
// entry 0 is written while reset is held. A stalled result waits in the
// output register and the next command is taken meanwhile, then held before
// its result.
// ----------------------------------------------------------------------------
module range_free_list_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // count[20:0], offset[40:21], zero pad
    input  logic [1:0]  s_tuser,   // cmd[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // alloc_offset[19:0], pool_empty[20], zero pad
    output logic [1:0]  m_tuser,   // status[1:0]
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    frla_pkg::frla_ctrl_t ctrl;
    frla_pkg::frla_stat_t stat;
    logic        cfg_we;
    logic [20:0] total_count;
    logic [19:0] alloc_offset;
    logic        pool_empty;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr == frla_pkg::REG_TOTAL_COUNT);
    assign prdata = (paddr == frla_pkg::REG_TOTAL_COUNT) ? {11'd0, total_count} : 32'd0;

    frla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    frla_datapath u_datapath (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .ctrl           (ctrl),
        .stat           (stat),
        .in_cmd         (s_tuser),
        .in_count       (s_tdata[20:0]),
        .in_offset      (s_tdata[40:21]),
        .cfg_we         (cfg_we),
        .cfg_data       (pwdata[20:0]),
        .total_count    (total_count),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_status       (m_tuser),
        .m_alloc_offset (alloc_offset),
        .m_pool_empty   (pool_empty)
    );

    assign m_tdata = {3'd0, pool_empty, alloc_offset};

endmodule

// ===== tb/range_free_list_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_free_list_checker
// Watches the command and result streams and the APB writes, keeps its own
// model of the free-range table and compares every result with it.
// ----------------------------------------------------------------------------
module range_free_list_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [47:0] s_tdata,
    input  logic [1:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic [1:0]  m_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [1:0]                     status;
        logic [frla_pkg::SLOT_BITS-1:0] grant;
        logic                           empty;
    } alloc_result_t;

    localparam longint MAX_SLOT = (64'd1 << frla_pkg::SLOT_BITS) - 1;

    longint        pool_total;
    longint        tbl_first [frla_pkg::MAX_RANGES];
    longint        tbl_last  [frla_pkg::MAX_RANGES];
    int            tbl_used;
    alloc_result_t result_q [$];

    function automatic longint eff_pool();
        longint t;
        t = pool_total;
        if (t < 1) t = 1;
        if (t > MAX_SLOT + 1) t = MAX_SLOT + 1;
        return t;
    endfunction

    function automatic longint span(int i);
        if (tbl_first[i] > tbl_last[i]) return 0;
        return tbl_last[i] + 1 - tbl_first[i];
    endfunction

    task automatic restore_ranges();
        for (int i = 0; i < frla_pkg::MAX_RANGES; i++) begin
            tbl_first[i] = 0;
            tbl_last[i] = 0;
        end
        tbl_last[0] = eff_pool() - 1;
        tbl_used = 1;
    endtask

    task automatic take_slots(longint cnt, output logic [1:0] st, output longint grant);
        longint sz;
        grant = 0;
        st = frla_pkg::STATUS_REFUSED;
        if (cnt == 0) return;
        for (int i = 0; i < tbl_used; i++) begin
            sz = span(i);
            if (cnt <= sz) begin
                grant = tbl_first[i];
                if (cnt == sz && i + 1 < tbl_used) begin
                    for (int j = i; j + 1 < tbl_used; j++) begin
                        tbl_first[j] = tbl_first[j+1];
                        tbl_last[j] = tbl_last[j+1];
                    end
                    tbl_used--;
                    tbl_first[tbl_used] = 0;
                    tbl_last[tbl_used] = 0;
                end else begin
                    tbl_first[i] += cnt;
                end
                st = frla_pkg::STATUS_DONE;
                return;
            end
        end
    endtask

    function automatic logic [1:0] give_back(longint offs, longint cnt);
        longint off, lst, merged;
        int i;
        if (cnt == 0) return frla_pkg::STATUS_REFUSED;
        off = offs;
        if (off > MAX_SLOT) off = MAX_SLOT;
        lst = off + cnt - 1;
        if (lst > MAX_SLOT) lst = MAX_SLOT;
        i = 0;
        while (i < tbl_used && tbl_first[i] < lst + 1) i++;
        if (i > 0 && tbl_last[i-1] + 1 == off) begin
            merged = tbl_last[i-1] + cnt;
            if (merged > MAX_SLOT) merged = MAX_SLOT;
            tbl_last[i-1] = merged;
            return frla_pkg::STATUS_DONE;
        end
        if (tbl_used >= frla_pkg::MAX_RANGES) return frla_pkg::STATUS_FULL;
        for (int j = tbl_used; j > i; j--) begin
            tbl_first[j] = tbl_first[j-1];
            tbl_last[j] = tbl_last[j-1];
        end
        tbl_first[i] = off;
        tbl_last[i] = lst;
        tbl_used++;
        return frla_pkg::STATUS_DONE;
    endfunction

    task automatic predict(logic [1:0] cmd, longint cnt, longint offs);
        alloc_result_t r;
        longint grant;
        logic [1:0] st;
        st = frla_pkg::STATUS_DONE;
        grant = 0;
        if (cmd == frla_pkg::CMD_ALLOC) take_slots(cnt, st, grant);
        else if (cmd == frla_pkg::CMD_FREE) st = give_back(offs, cnt);
        else if (cmd == frla_pkg::CMD_RESTORE) restore_ranges();
        r.status = st;
        r.grant = grant[frla_pkg::SLOT_BITS-1:0];
        r.empty = (tbl_used == 1 && span(0) == eff_pool());
        result_q.push_back(r);
    endtask

    assign pending = result_q.size();

    always @(posedge aclk) begin
        alloc_result_t exp_r, got;
        if (!aresetn) begin
            pool_total = 1048576;
            restore_ranges();
            result_q.delete();
            fail_count = 0;
        end else begin
            if (psel && penable && pwrite && pready
                && paddr == 3'(4 * frla_pkg::REG_TOTAL_COUNT)) begin
                pool_total = pwdata[20:0];
                restore_ranges();
            end
            if (m_tvalid && m_tready) begin
                got.status = m_tuser;
                got.grant = m_tdata[19:0];
                got.empty = m_tdata[20];
                if (result_q.size() == 0) begin
                    $display("%0t: unexpected result %h", $time, got);
                    fail_count++;
                end else begin
                    exp_r = result_q.pop_front();
                    if (got !== exp_r) begin
                        $display("%0t: expected st=%0d off=%h empty=%b, %s",
                                 $time, exp_r.status, exp_r.grant, exp_r.empty,
                                 $sformatf("got st=%0d off=%h empty=%b",
                                           got.status, got.grant, got.empty));
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                predict(s_tuser, s_tdata[20:0], s_tdata[40:21]);
        end
    end

endmodule

// ===== tb/tb_range_free_list_allocator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_range_free_list_allocator
// Directed and random allocate, free and restore commands over several pool
// sizes, with random gaps on both streams; the checker compares each result.
// ----------------------------------------------------------------------------
module tb_range_free_list_allocator;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count;
    int          pending;
    int          idle_cycles;
    int          pool_now;

    range_free_list_allocator u_dut (.*);

    range_free_list_checker u_checker (.*);

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    // random receiver stalls, with stretches of none
    initial begin
        m_tready = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
            if ($urandom_range(0, 2) != 0) begin
                m_tready <= 1'b0;
                repeat (gap_len() + 1) @(posedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 5000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic send_cmd(logic [1:0] cmd, int cnt, int offs);
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= {7'd0, offs[19:0], cnt[20:0]};
        @(posedge aclk iff s_tready);
        s_tvalid <= 1'b0;
        repeat (gap_len() + 1) @(posedge aclk);
    endtask

    task automatic write_pool(int value);
        while (pending != 0) @(posedge aclk);
        repeat (150) @(posedge aclk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * frla_pkg::REG_TOTAL_COUNT);
        pwdata <= 32'(value);
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge aclk);
        pool_now = (value & 32'h1FFFFF) == 0 ? 1 : ((value & 32'h1FFFFF) > 1048576 ?
                   1048576 : (value & 32'h1FFFFF));
    endtask

    function automatic int rnd_count();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return $urandom_range(0, 2097151);
            2: return $urandom_range(1, pool_now);
            default: return $urandom_range(1, (pool_now > 64) ? pool_now / 16 : pool_now);
        endcase
    endfunction

    // allocations, frees of the same sizes at random places, plus noise
    task automatic random_phase(int n);
        int held_off [$];
        int held_cnt [$];
        int k, cnt, c;
        for (int i = 0; i < n; i++) begin
            c = $urandom_range(0, 99);
            if (c < 45) begin
                cnt = rnd_count();
                send_cmd(frla_pkg::CMD_ALLOC, cnt, $urandom_range(0, 1048575));
                held_off.push_back($urandom_range(0, pool_now - 1));
                held_cnt.push_back(cnt);
            end else if (c < 85 && held_off.size() > 0) begin
                k = $urandom_range(0, held_off.size() - 1);
                send_cmd(frla_pkg::CMD_FREE, held_cnt[k], held_off[k]);
                held_off.delete(k);
                held_cnt.delete(k);
            end else if (c < 95) begin
                send_cmd(frla_pkg::CMD_FREE, rnd_count(), $urandom_range(0, 1048575));
            end else if (c < 98) begin
                send_cmd(2'($urandom_range(2, 3)), $urandom_range(0, 2097151),
                         $urandom_range(0, 1048575));
            end else begin
                send_cmd(frla_pkg::CMD_RESTORE, 0, 0);
            end
        end
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        pool_now = 1048576;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes, zero count, overflow, clipping, unused selector
        send_cmd(frla_pkg::CMD_ALLOC, 0, 0);
        send_cmd(frla_pkg::CMD_ALLOC, 2097151, 0);
        send_cmd(frla_pkg::CMD_ALLOC, 1048576, 0);
        send_cmd(frla_pkg::CMD_ALLOC, 1, 0);
        send_cmd(frla_pkg::CMD_FREE, 0, 5);
        send_cmd(frla_pkg::CMD_FREE, 1048576, 0);
        send_cmd(frla_pkg::CMD_RESTORE, 0, 0);
        send_cmd(frla_pkg::CMD_ALLOC, 10, 0);
        send_cmd(frla_pkg::CMD_ALLOC, 10, 0);
        send_cmd(frla_pkg::CMD_FREE, 10, 0);
        send_cmd(frla_pkg::CMD_FREE, 10, 10);
        send_cmd(frla_pkg::CMD_FREE, 2097151, 1048575);
        send_cmd(frla_pkg::CMD_FREE, 5, 3);
        send_cmd(2'd3, 2097151, 1048575);
        send_cmd(frla_pkg::CMD_RESTORE, 2097151, 1048575);
        // fill the table: odd slots allocated, even ones freed
        send_cmd(frla_pkg::CMD_ALLOC, 200, 0);
        for (int i = 0; i < 70; i++) send_cmd(frla_pkg::CMD_FREE, 1, 2 * i);
        send_cmd(frla_pkg::CMD_ALLOC, 1, 0);
        send_cmd(frla_pkg::CMD_ALLOC, 1048576, 0);

        write_pool(0);
        send_cmd(frla_pkg::CMD_ALLOC, 1, 0);
        send_cmd(frla_pkg::CMD_ALLOC, 1, 0);
        send_cmd(frla_pkg::CMD_FREE, 1, 0);
        write_pool(32'hFFFFFFFF);
        random_phase(300);
        write_pool(1048576);
        random_phase(400);
        write_pool(100);
        random_phase(400);
        write_pool(2000);
        random_phase(350);
        write_pool(1);
        random_phase(100);

        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
